// ===== hdl/fixed_block_free_list_allocator_unit_macros.svh =====
// assertion macros for the fixed block free list allocator unit
// no dependencies; included by the files that carry assertions
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define FBLA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fbla assertion failed");
// clocked check that also holds through reset
`define FBLA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("fbla assertion failed");
`else
`define FBLA_ASSERT(lbl, clk, rst_n, prop)
`define FBLA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/fbla_pkg.sv =====
// shared types, constants and helpers of the fixed block free list allocator
// no dependencies
package fbla_pkg;

  // field widths
  localparam int MODE_W   = 2;
  localparam int OFFSET_W = 20;
  localparam int STATUS_W = 3;
  localparam int BS_W     = 13;

  // parameter defaults
  localparam int NUM_BLOCKS_DEF = 256;
  localparam int ADDR_BITS_DEF  = 20;

  // block size register
  localparam logic [BS_W-1:0] BS_RESET = 13'd64;
  localparam logic [BS_W-1:0] BS_MIN   = 13'd16;
  localparam logic [BS_W-1:0] BS_MAX   = 13'd4096;

  // request codes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHUT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALIGN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DOUBLE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOINIT = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SHUT   = 3'd6;

  // divider result bundle
  typedef struct packed {
    logic                done;
    logic [OFFSET_W-1:0] quotient;
    logic [BS_W-1:0]     remainder;
  } div_res_t;

  // clamp the block size into its legal range
  function automatic logic [BS_W-1:0] bs_sat(input logic [BS_W-1:0] b);
    logic [BS_W-1:0] r;
    r = b;
    if (b < BS_MIN) r = BS_MIN;
    else if (b > BS_MAX) r = BS_MAX;
    return r;
  endfunction

endpackage

// ===== hdl/fbla_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module fbla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fbla_div.sv =====
// bit serial restoring divider, offset by block size, one quotient bit per cycle
// depends on fbla_pkg and the assertion macro header
`include "fixed_block_free_list_allocator_unit_macros.svh"
module fbla_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fbla_pkg::OFFSET_W-1:0] dividend_i,
  input  logic [fbla_pkg::BS_W-1:0]     divisor_i,
  output fbla_pkg::div_res_t            res_o
);

  localparam int DW    = fbla_pkg::OFFSET_W;
  localparam int RW    = fbla_pkg::BS_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [RW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    quo_q, quo_d;
  logic [RW-1:0]    div_q, div_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RW:0]      trial;
  logic [RW:0]      diff;
  logic             ge;

  // load on start, else one restoring step on the shared subtractor
  always_comb begin
    trial  = {rem_q, quo_q[DW-1]};
    diff   = trial - {1'b0, div_q};
    ge     = (trial >= {1'b0, div_q});
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = CNT_W'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[RW-1:0] : trial[RW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

  `FBLA_ASSERT(a_div_no_restart, clk_i, rst_ni, start_i |-> !busy_q)
  `FBLA_ASSERT(a_div_done_after_run, clk_i, rst_ni, done_q |-> $past(busy_q) && !busy_q)

endmodule

// ===== hdl/fixed_block_free_list_allocator_unit.sv =====
// Fixed block allocator: a LIFO free list over NUM_BLOCKS equal blocks, with a
// per-block free flag, handling allocate, free, shutdown leak check and initialize.
// A request is taken when start_i is high and busy_o low; its one result appears
// on status_o, block_address_o and leaks_found_o for exactly one cycle with done_o
// and must be captured then, since the receiver cannot stall the block.
// Shutdown, initialize and any request refused at once give their result in the
// cycle after the transfer with busy_o staying low; an allocate passes through
// S_ALLOC for its read of the next-index memory; a free that reaches the divider
// runs the 20-step bit serial offset by block size division: the divider loads,
// takes its 20 steps, the quotient is taken in S_DIV and the block memory is read
// for S_FREE; a free refused for range or alignment ends in S_DIV without that read.
// No clearing pass follows reset: a fill mark tells never-touched blocks apart.
// Depends on fbla_pkg, fbla_div, fbla_ram and the assertion macro header.
`include "fixed_block_free_list_allocator_unit_macros.svh"
module fixed_block_free_list_allocator_unit #(
  parameter int NUM_BLOCKS = fbla_pkg::NUM_BLOCKS_DEF,
  parameter int ADDR_BITS  = fbla_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [fbla_pkg::MODE_W-1:0]   mode_i,
  input  logic [fbla_pkg::OFFSET_W-1:0] block_offset_i,
  input  logic                          block_size_we_i,
  input  logic [fbla_pkg::BS_W-1:0]     block_size_wdata_i,
  output logic                          done_o,
  output logic [fbla_pkg::STATUS_W-1:0] status_o,
  output logic [fbla_pkg::OFFSET_W-1:0] block_address_o,
  output logic                          leaks_found_o
);

  localparam int FW        = fbla_pkg::OFFSET_W;
  localparam int IDX_W     = $clog2(NUM_BLOCKS);
  localparam int HEAD_W    = $clog2(NUM_BLOCKS + 1);
  localparam int WORD_W    = HEAD_W + 1;
  localparam int PROD_W    = IDX_W + fbla_pkg::BS_W;
  localparam int MASK_BITS = (ADDR_BITS < FW) ? ADDR_BITS : FW;
  localparam logic [FW-1:0] ADDR_MASK = FW'((64'd1 << MASK_BITS) - 64'd1);
  localparam logic [HEAD_W-1:0] NULL_IDX = HEAD_W'(NUM_BLOCKS);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_FREE  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [HEAD_W-1:0]             head_q, head_d;
  logic [HEAD_W-1:0]             fill_q, fill_d;
  logic [HEAD_W-1:0]             count_q, count_d;
  logic                          shut_q, shut_d;
  logic [fbla_pkg::BS_W-1:0]     bs_q;
  logic [fbla_pkg::BS_W-1:0]     bs_eff;
  logic [IDX_W-1:0]              blk_q, blk_d;
  logic [PROD_W-1:0]             prod_q, prod_d;
  logic [31:0]                   prod_ext;
  logic                          done_q, done_d;
  logic [fbla_pkg::STATUS_W-1:0] status_q, status_d;
  logic [FW-1:0]                 addr_q, addr_d;
  logic                          leaks_q, leaks_d;
  logic                          accept;
  logic                          div_start;
  fbla_pkg::div_res_t            div_res;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [WORD_W-1:0]             ram_wdata;
  logic [IDX_W-1:0]              ram_raddr;
  logic [WORD_W-1:0]             ram_rdata;
  logic [HEAD_W-1:0]             next_idx;
  logic                          blk_free;

  assign accept   = start_i && (state_q == S_IDLE);
  assign bs_eff   = fbla_pkg::bs_sat(bs_q);
  assign prod_ext = 32'(prod_q);

  // next index of the head: untouched blocks chain to their successor
  assign next_idx = (head_q >= fill_q) ? (head_q + HEAD_W'(1)) : ram_rdata[HEAD_W-1:0];
  // free flag of the block being released: untouched blocks are free
  assign blk_free = (HEAD_W'(blk_q) >= fill_q) ? 1'b1 : ram_rdata[HEAD_W];

  // shared offset divider
  fbla_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (block_offset_i & ADDR_MASK),
    .divisor_i  (bs_eff),
    .res_o      (div_res)
  );

  // next index and free flag per block
  fbla_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // request sequencer
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    fill_d    = fill_q;
    count_d   = count_q;
    shut_d    = shut_q;
    blk_d     = blk_q;
    prod_d    = prod_q;
    done_d    = 1'b0;
    status_d  = status_q;
    addr_d    = addr_q;
    leaks_d   = leaks_q;
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = head_q[IDX_W-1:0];
    ram_wdata = '0;
    ram_raddr = head_q[IDX_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            fbla_pkg::MODE_ALLOC: begin
              if (shut_q) begin
                done_d   = 1'b1;
                status_d = fbla_pkg::ST_NOINIT;
                addr_d   = '0;
                leaks_d  = 1'b0;
              end else if (head_q == NULL_IDX) begin
                done_d   = 1'b1;
                status_d = fbla_pkg::ST_EMPTY;
                addr_d   = '0;
                leaks_d  = 1'b0;
              end else begin
                prod_d  = head_q[IDX_W-1:0] * bs_eff;
                state_d = S_ALLOC;
              end
            end
            fbla_pkg::MODE_FREE: begin
              if (shut_q) begin
                done_d   = 1'b1;
                status_d = fbla_pkg::ST_NOINIT;
                addr_d   = '0;
                leaks_d  = 1'b0;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            fbla_pkg::MODE_SHUT: begin
              done_d = 1'b1;
              addr_d = '0;
              if (shut_q) begin
                status_d = fbla_pkg::ST_SHUT;
                leaks_d  = 1'b0;
              end else begin
                status_d = fbla_pkg::ST_OK;
                leaks_d  = (count_q != '0);
                shut_d   = 1'b1;
              end
            end
            fbla_pkg::MODE_INIT: begin
              head_d   = '0;
              fill_d   = '0;
              count_d  = '0;
              shut_d   = 1'b0;
              done_d   = 1'b1;
              status_d = fbla_pkg::ST_OK;
              addr_d   = '0;
              leaks_d  = 1'b0;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_ALLOC: begin
        // pop the head and mark it taken
        ram_we    = 1'b1;
        ram_waddr = head_q[IDX_W-1:0];
        ram_wdata = {1'b0, next_idx};
        head_d    = next_idx;
        if (head_q == fill_q) begin
          fill_d = fill_q + HEAD_W'(1);
        end
        count_d  = count_q + HEAD_W'(1);
        done_d   = 1'b1;
        status_d = fbla_pkg::ST_OK;
        addr_d   = prod_ext[FW-1:0] & ADDR_MASK;
        leaks_d  = 1'b0;
        state_d  = S_IDLE;
      end
      S_DIV: begin
        if (div_res.done) begin
          if (div_res.quotient >= FW'(NUM_BLOCKS)) begin
            done_d   = 1'b1;
            status_d = fbla_pkg::ST_RANGE;
            addr_d   = '0;
            leaks_d  = 1'b0;
            state_d  = S_IDLE;
          end else if (div_res.remainder != '0) begin
            done_d   = 1'b1;
            status_d = fbla_pkg::ST_ALIGN;
            addr_d   = '0;
            leaks_d  = 1'b0;
            state_d  = S_IDLE;
          end else begin
            blk_d     = div_res.quotient[IDX_W-1:0];
            ram_raddr = div_res.quotient[IDX_W-1:0];
            state_d   = S_FREE;
          end
        end
      end
      S_FREE: begin
        // push the block unless it is already free
        done_d  = 1'b1;
        addr_d  = '0;
        leaks_d = 1'b0;
        if (blk_free) begin
          status_d = fbla_pkg::ST_DOUBLE;
        end else begin
          status_d  = fbla_pkg::ST_OK;
          ram_we    = 1'b1;
          ram_waddr = blk_q;
          ram_wdata = {1'b1, head_q};
          head_d    = HEAD_W'(blk_q);
          count_d   = count_q - HEAD_W'(1);
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and block size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      fill_q  <= '0;
      count_q <= '0;
      shut_q  <= 1'b0;
      done_q  <= 1'b0;
      bs_q    <= fbla_pkg::BS_RESET;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      shut_q  <= shut_d;
      done_q  <= done_d;
      if (block_size_we_i) begin
        bs_q <= block_size_wdata_i;
      end
    end
  end

  // result and working registers
  always_ff @(posedge clk_i) begin
    blk_q    <= blk_d;
    prod_q   <= prod_d;
    status_q <= status_d;
    addr_q   <= addr_d;
    leaks_q  <= leaks_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign block_address_o = addr_q;
  assign leaks_found_o   = leaks_q;

  `FBLA_ASSERT(a_done_has_cause, clk_i, rst_ni, done_o |-> $past(start_i && !busy_o) || $past(busy_o))
  `FBLA_ASSERT(a_list_bounds, clk_i, rst_ni, (count_q <= NULL_IDX) && (fill_q <= NULL_IDX) && (head_q <= NULL_IDX))
  `FBLA_ASSERT(a_alloc_counts, clk_i, rst_ni, (state_q == S_ALLOC) |=> (count_q == $past(count_q) + HEAD_W'(1)))
  `FBLA_ASSERT(a_leak_only_ok, clk_i, rst_ni, (done_o && leaks_found_o) |-> (status_o == fbla_pkg::ST_OK))

endmodule
